// File: design/fsp_pkg.sv
// ----------------------------------------------------------------------------
// fsp_pkg
// shared types, codes, constants and helper functions of the frame skip pacer
// ----------------------------------------------------------------------------
package fsp_pkg;

   // largest run of consecutive skipped iterations (1 to 8)
   localparam int SKIP_CAP = 1;

   localparam int VBLANK_US   = 16683;
   localparam int REANCHOR_VB = 30;
   localparam int IDLE_LIMIT  = 4;
   localparam int STALE_LIMIT = 32;
   localparam int FLOOR_RESET = 66666;

   // rest / VBLANK_US as (rest * RECIP) >> RECIP_SHIFT, exact for any 32-bit rest
   // RECIP = ceil(2^47 / 16683), error term 1309 < 2^15
   localparam logic [32:0] RECIP       = 33'd8435982039;
   localparam int          RECIP_SHIFT = 47;
   localparam int          QUO_W       = 18;

   typedef enum logic [2:0] {
      REQ_BEGIN  = 3'd0,
      REQ_DECIDE = 3'd1,
      REQ_RENDER = 3'd2,
      REQ_END    = 3'd3,
      REQ_ITASK  = 3'd4,
      REQ_RESET  = 3'd5
   } req_kind_type;

   localparam logic [1:0] MODE_SMOOTH = 2'd0;
   localparam logic [1:0] MODE_FAST   = 2'd1;
   localparam logic [1:0] MODE_OFF    = 2'd2;

   localparam logic [1:0] VAR_NEVER = 2'd0;
   localparam logic [1:0] VAR_BEGIN = 2'd1;
   localparam logic [1:0] VAR_AHEAD = 2'd2;

   localparam logic [1:0] CSR_MODE       = 2'd0;
   localparam logic [1:0] CSR_VARIANT    = 2'd1;
   localparam logic [1:0] CSR_FLOOR      = 2'd2;

   typedef struct packed {
      logic [1:0]  mode_sel;
      logic [1:0]  catchup_variant;
      logic [19:0] floor_period_us;
   } cfg_type;

   typedef struct packed {
      req_kind_type req_type;
      logic [31:0]  retrace_count;
      logic [47:0]  time_us;
      logic [3:0]   vsync_divisor;
      logic         in_play;
   } item_type;

   typedef struct packed {
      logic        skipping;
      logic        drop_models;
      logic        paced;
      logic [31:0] due_vblank;
      logic        itask_run;
   } result_type;

   function automatic logic [31:0] sat32(input logic [47:0] v);
      sat32 = (v[47:32] != 16'd0) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   // eighth-weight moving average, first sample taken as is
   function automatic logic [31:0] ema8(input logic [31:0] e, input logic [31:0] v);
      ema8 = (e == 32'd0) ? v : (e - (e >> 3) + (v >> 3));
   endfunction

   // smooth mode floor: estimated present-to-present gap exceeds the limit
   function automatic logic gap_exceeded(input cfg_type     cfg,
                                         input logic [31:0] draw,
                                         input logic [31:0] skipc_raw,
                                         input logic [31:0] rend,
                                         input logic [48:0] since);
      logic [31:0] skipc;
      logic [50:0] gap;
      skipc = skipc_raw;
      if (skipc_raw == 32'd0) begin
         skipc = (draw > rend) ? (draw - rend) : 32'd0;
      end
      gap = {2'b00, since} + {19'd0, skipc} + {19'd0, draw};
      gap_exceeded = (cfg.mode_sel == MODE_SMOOTH) && (gap > {31'd0, cfg.floor_period_us});
   endfunction

endpackage

// File: design/fsp_vblank_div.sv
// ----------------------------------------------------------------------------
// fsp_vblank_div
// registered quotient of the decide-to-end cost estimate by one vblank period
// ----------------------------------------------------------------------------
module fsp_vblank_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [31:0]              rest,
   input  logic                     rest_we,
   output logic [fsp_pkg::QUO_W-1:0] quo,
   output logic                     quo_ok
);
   import fsp_pkg::*;

   logic [64:0]      prod;
   logic [QUO_W-1:0] quo_ff;
   logic             quo_ok_ff;
   logic             quo_ok_in;

   // reciprocal multiply, quotient taken from the top bits
   assign prod = {33'd0, rest} * {32'd0, RECIP};

   // quotient register trails the estimate, so quo_ok drops after each update
   assign quo_ok_in = !rest_we;

   always_ff @(posedge clock) begin
      quo_ff <= prod[RECIP_SHIFT +: QUO_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quo_ok_ff <= 1'b0;
      end else begin
         quo_ok_ff <= quo_ok_in;
      end
   end

   assign quo    = quo_ff;
   assign quo_ok = quo_ok_ff;

endmodule

// File: design/fsp_core.sv
// ----------------------------------------------------------------------------
// fsp_core
// pacing state and the single-pass update for one event
// ----------------------------------------------------------------------------
module fsp_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  fsp_pkg::item_type         item,
   input  fsp_pkg::cfg_type          cfg,
   input  logic [fsp_pkg::QUO_W-1:0] quo,
   output fsp_pkg::result_type       res,
   output logic [31:0]               rest,
   output logic                      rest_we
);
   import fsp_pkg::*;

   typedef struct packed {
      logic        ok_now;
      logic        clock_active;
      logic [3:0]  prev_divisor;
      logic [31:0] anchor_vblank;
      logic [31:0] tick_count;
      logic [3:0]  skip_run;
      logic        drop_pending;
      logic        skip_flag;
      logic [47:0] iter_start_us;
      logic [47:0] decide_time_us;
      logic [47:0] last_present_time;
      logic [31:0] cost_draw;
      logic [31:0] cost_skip;
      logic [31:0] cost_rest;
      logic [31:0] cost_render;
      logic [5:0]  drawn_iters;
      logic [2:0]  itask_idle_count;
   } state_type;

   state_type st_ff;
   state_type st_in;

   logic        ahead;
   logic        run_ok;
   logic [47:0] since_present;
   logic [31:0] iter_cost;
   logic [31:0] decide_cost;

   // begin event
   logic        b_ok;
   logic        b_reanchor;
   logic [31:0] b_anchor0;
   logic [31:0] b_tick0;
   logic [31:0] b_lag;
   logic        b_far;
   logic        b_over;
   logic [31:0] b_anchor;
   logic        b_lag_low;
   logic        b_want;

   // decide event and end event
   logic [31:0] d_target;
   logic [31:0] d_diff;
   logic [33:0] d_lag;
   logic [48:0] d_since;
   logic        d_cond;
   logic        d_drop;
   logic [31:0] tick_next;
   logic [5:0]  iss_next;
   logic [2:0]  idle_next;

   assign ahead         = cfg.catchup_variant[1];
   assign run_ok        = st_ff.skip_run < 4'(SKIP_CAP);
   assign since_present = item.time_us - st_ff.last_present_time;
   assign iter_cost     = sat32(item.time_us - st_ff.iter_start_us);
   assign decide_cost   = sat32(item.time_us - st_ff.decide_time_us);

   assign b_ok       = (item.vsync_divisor == 4'd2) && (cfg.mode_sel != MODE_OFF)
                       && item.in_play;
   assign b_reanchor = !st_ff.clock_active || (item.vsync_divisor != st_ff.prev_divisor);
   assign b_anchor0  = b_reanchor ? item.retrace_count : st_ff.anchor_vblank;
   assign b_tick0    = b_reanchor ? 32'd0 : st_ff.tick_count;
   assign b_lag      = item.retrace_count - (b_anchor0 + {b_tick0[30:0], 1'b0});
   assign b_far      = $signed(b_lag) > 32'sd30;
   assign b_over     = $signed(b_lag) > $signed(32'(2 * (SKIP_CAP + 1)));
   assign b_anchor   = b_far  ? (item.retrace_count - {b_tick0[30:0], 1'b0}) :
                       b_over ? (b_anchor0 + (b_lag - 32'(2 * SKIP_CAP))) : b_anchor0;
   assign b_lag_low  = b_far ? 1'b1 :
                       b_over ? 1'(2 * SKIP_CAP < 2) : ($signed(b_lag) < 32'sd2);
   assign b_want     = !b_lag_low && run_ok
                       && !gap_exceeded(cfg, st_ff.cost_draw, st_ff.cost_skip,
                                        st_ff.cost_render, {1'b0, since_present});

   // next tick target, shared by the decide lag and the end due vblank
   assign tick_next = st_ff.tick_count + 32'd1;
   assign d_target  = st_ff.anchor_vblank + {tick_next[30:0], 1'b0};
   assign d_diff    = item.retrace_count - d_target;
   assign d_lag     = {{2{d_diff[31]}}, d_diff} + {{(34 - QUO_W){1'b0}}, quo};
   assign d_since   = st_ff.skip_flag ? ({1'b0, since_present} + {17'd0, st_ff.cost_rest})
                                      : 49'd0;
   assign d_cond    = st_ff.ok_now && st_ff.clock_active && (cfg.mode_sel != MODE_OFF)
                      && item.in_play;
   assign d_drop    = d_cond && !($signed(d_lag) < 34'sd2) && run_ok
                      && !gap_exceeded(cfg, st_ff.cost_draw, st_ff.cost_skip,
                                       st_ff.cost_render, d_since);

   assign iss_next  = (st_ff.drawn_iters < 6'd63) ? (st_ff.drawn_iters + 6'd1)
                                                   : st_ff.drawn_iters;
   assign idle_next = st_ff.itask_idle_count + 3'd1;

   always_comb begin
      logic skip;
      st_in   = st_ff;
      res     = '0;
      rest_we = 1'b0;
      skip    = 1'b0;
      case (item.req_type)
         REQ_BEGIN: begin
            st_in.iter_start_us  = item.time_us;
            st_in.decide_time_us = item.time_us;
            st_in.ok_now         = b_ok;
            if (!b_ok) begin
               st_in.clock_active = 1'b0;
            end else begin
               st_in.clock_active  = 1'b1;
               st_in.anchor_vblank = b_anchor;
               st_in.tick_count    = b_tick0;
               if (cfg.catchup_variant == VAR_BEGIN) begin
                  skip = b_want;
               end
            end
            st_in.prev_divisor = item.vsync_divisor;
            if (ahead) begin
               skip               = st_ff.drop_pending;
               st_in.drop_pending = 1'b0;
            end
            if (skip) begin
               if (st_ff.skip_run < 4'd15) begin
                  st_in.skip_run = st_ff.skip_run + 4'd1;
               end
            end else begin
               st_in.skip_run = 4'd0;
            end
            st_in.skip_flag = skip;
         end
         REQ_DECIDE: begin
            if (ahead) begin
               st_in.decide_time_us = item.time_us;
               st_in.drop_pending   = d_drop;
               res.drop_models      = d_drop;
            end
         end
         REQ_RENDER: begin
            if (!st_ff.skip_flag) begin
               st_in.cost_render = ema8(st_ff.cost_render, iter_cost);
            end
         end
         REQ_END: begin
            if (st_ff.skip_flag) begin
               st_in.cost_skip   = ema8(st_ff.cost_skip, iter_cost);
               st_in.drawn_iters = 6'd0;
            end else begin
               st_in.cost_draw         = ema8(st_ff.cost_draw, iter_cost);
               st_in.last_present_time = item.time_us;
               st_in.drawn_iters       = iss_next;
               if (iss_next > 6'(STALE_LIMIT)) begin
                  st_in.cost_skip = 32'd0;
               end
            end
            if (ahead) begin
               st_in.cost_rest = ema8(st_ff.cost_rest, decide_cost);
               rest_we         = fire;
            end
            if (st_ff.clock_active) begin
               st_in.tick_count = tick_next;
               res.due_vblank   = d_target;
               res.paced        = 1'b1;
            end
            st_in.skip_flag = 1'b0;
         end
         REQ_ITASK: begin
            if (!st_ff.skip_flag) begin
               st_in.itask_idle_count = 3'd0;
               res.itask_run          = 1'b1;
            end else if (idle_next >= 3'(IDLE_LIMIT)) begin
               st_in.itask_idle_count = 3'd0;
               res.itask_run          = 1'b1;
            end else begin
               st_in.itask_idle_count = idle_next;
            end
         end
         REQ_RESET: begin
            st_in.clock_active = 1'b0;
            st_in.ok_now       = 1'b0;
            st_in.skip_run     = 4'd0;
            st_in.drop_pending = 1'b0;
            st_in.skip_flag    = 1'b0;
         end
         default: begin
         end
      endcase
      res.skipping = st_in.skip_flag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (fire) begin
         st_ff <= st_in;
      end
   end

   assign rest = st_ff.cost_rest;

endmodule

// File: design/frame_skip_pacer.sv
// ----------------------------------------------------------------------------
// frame_skip_pacer
// frame skip decisions and tick deadlines for a two-vblank game loop
// ----------------------------------------------------------------------------
// usage
//   req_*  : one beat per game-loop event (begin, decide image, render done,
//            end, itask query, reset), kind in req_tuser
//   rsp_*  : exactly one result beat per event, in event order
//   csr_*  : register writes (pace mode, catch-up variant, floor period),
//            always ready, only while no event is in flight
// timing
//   an accepted beat waits in the input register until it fires; its result
//   is then registered in the result register, which drives rsp_tvalid
//   one event per cycle while no hold or result stall stands in the way; a
//   decide event that directly follows an end event in variant 2 or 3 is
//   held until the registered reciprocal multiplier has turned the new
//   decide-to-end cost into vblanks
// reset
//   synchronous; clears all pacing state, both beat registers and the
//   registers to mode smooth, variant 1, floor 66666 us
// back-pressure
//   a stalled rsp holds its beat; the input register still takes one more
//   beat, then req_tready drops until the result register drains
// ----------------------------------------------------------------------------
module frame_skip_pacer (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // retrace_count[31:0], time_us[79:32], vsync_divisor[83:80],
   // in_play[84], zero[87:85]
   input  logic [87:0] req_tdata,
   // req_type[2:0]
   input  logic [2:0]  req_tuser,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // skipping[0], drop_models[1], paced[2], due_vblank[34:3], itask_run[35],
   // zero[39:36]
   output logic [39:0] rsp_tdata,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_data
);
   import fsp_pkg::*;

   // register file
   cfg_type    cfg_ff;
   cfg_type    cfg_in;

   // input and result registers
   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   in_item_ff;
   item_type   req_item;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_res_ff;
   result_type core_res;

   logic       req_beat;
   logic       fire;
   logic       hold;

   logic [31:0]      rest;
   logic             rest_we;
   logic [QUO_W-1:0] quo;
   logic             quo_ok;

   // ---- configuration ------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MODE:    cfg_in.mode_sel        = csr_data[1:0];
            CSR_VARIANT: cfg_in.catchup_variant = csr_data[1:0];
            CSR_FLOOR:   cfg_in.floor_period_us = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode_sel        <= MODE_SMOOTH;
         cfg_ff.catchup_variant <= VAR_BEGIN;
         cfg_ff.floor_period_us <= 20'(FLOOR_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- input register -----------------------------------------------------
   assign req_item.req_type      = req_kind_type'(req_tuser);
   assign req_item.retrace_count = req_tdata[31:0];
   assign req_item.time_us       = req_tdata[79:32];
   assign req_item.vsync_divisor = req_tdata[83:80];
   assign req_item.in_play       = req_tdata[84];

   // variant 2 or 3 decides need the quotient of the latest decide-to-end cost
   assign hold = (in_item_ff.req_type == REQ_DECIDE) && cfg_ff.catchup_variant[1]
                 && !quo_ok;

   // process the event if not held and the result register is free or draining
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready) && !hold;
   assign req_tready = !in_valid_ff || fire;
   assign req_beat   = req_tvalid && req_tready;

   assign in_valid_in  = req_beat || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_item_ff <= req_item;
      end
      if (fire) begin
         out_res_ff <= core_res;
      end
   end

   // ---- pacing core and cost quotient -------------------------------------
   fsp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .quo     (quo),
      .res     (core_res),
      .rest    (rest),
      .rest_we (rest_we)
   );

   fsp_vblank_div u_div (
      .clock   (clock),
      .reset   (reset),
      .rest    (rest),
      .rest_we (rest_we),
      .quo     (quo),
      .quo_ok  (quo_ok)
   );

   // ---- result channel -----------------------------------------------------
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_res_ff.itask_run, out_res_ff.due_vblank,
                        out_res_ff.paced, out_res_ff.drop_models, out_res_ff.skipping};

   // ---- assertions ---------------------------------------------------------
   // a decide event never runs on a stale quotient
   a_decide_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && (in_item_ff.req_type == REQ_DECIDE) && cfg_ff.catchup_variant[1]
       && !quo_ok) |-> !fire)
      else $error("decide event processed with stale cost quotient");

   // every processed event shows up as a result beat
   a_fire_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_tvalid)
      else $error("processed event produced no result beat");

   // an end event always leaves the iteration unskipped
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && (in_item_ff.req_type == REQ_END)) |=> !rsp_tdata[0])
      else $error("skipping still set after end event");

   // no stale result beat right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat valid right after reset");

endmodule

// File: tb/pacer_check_pkg.sv
// ----------------------------------------------------------------------------
// pacer_check_pkg
// event type and scoreboard for the frame skip pacer bench: mirrors the
// pacing state, works out the decision for every event and checks result beats
// ----------------------------------------------------------------------------
package pacer_check_pkg;

   import fsp_pkg::*;

   // register values with no name of their own in the block's package
   localparam logic [1:0] MODE_ALT   = 2'd3;
   localparam logic [1:0] VAR_ALT    = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // unused request codes
   localparam logic [2:0] REQ_SPARE_A = 3'd6;
   localparam logic [2:0] REQ_SPARE_B = 3'd7;

   localparam int SKIP_RUN_MAX = 15;
   localparam int DRAWN_MAX    = 63;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] retrace;
      logic [47:0] t_us;
      logic [3:0]  div;
      logic        ctx;
   } pacer_event_type;

   class pacer_scoreboard_type;

      logic [1:0]  mode;
      logic [1:0]  variant;
      logic [19:0] floor_us;

      bit          ok_now;
      bit          clock_run;
      bit          drop_pending;
      bit          skip_flag;
      logic [3:0]  prev_div;
      logic [31:0] anchor_vb;
      logic [31:0] ticks;
      logic [3:0]  skip_run;
      logic [47:0] iter_start;
      logic [47:0] decide_at;
      logic [47:0] last_present;
      // 0 drawn, 1 skipped, 2 decide to end, 3 begin to render done
      logic [31:0] cost [4];
      logic [5:0]  drawn_iters;
      logic [2:0]  idle_cnt;

      result_type  decisions [$];
      int          mismatches;

      function new();
         mode         = MODE_SMOOTH;
         variant      = VAR_BEGIN;
         floor_us     = 20'(FLOOR_RESET);
         ok_now       = 1'b0;
         clock_run    = 1'b0;
         drop_pending = 1'b0;
         skip_flag    = 1'b0;
         prev_div     = '0;
         anchor_vb    = '0;
         ticks        = '0;
         skip_run     = '0;
         iter_start   = '0;
         decide_at    = '0;
         last_present = '0;
         foreach (cost[i]) cost[i] = '0;
         drawn_iters  = '0;
         idle_cnt     = '0;
         mismatches   = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [19:0] data);
         case (idx)
            CSR_MODE:    mode = data[1:0];
            CSR_VARIANT: variant = data[1:0];
            CSR_FLOOR:   floor_us = data;
            default: ;
         endcase
      endfunction

      function logic [47:0] elapsed(logic [47:0] a, logic [47:0] b);
         return a - b;
      endfunction

      function logic [31:0] clip32(logic [47:0] v);
         return (v[47:32] != 16'd0) ? 32'hFFFF_FFFF : v[31:0];
      endfunction

      function logic [31:0] avg8(logic [31:0] e, logic [31:0] v);
         if (e == 32'd0) return v;
         return e - (e >> 3) + (v >> 3);
      endfunction

      // lag, skip cap and, in smooth mode, the present-to-present floor
      function bit skip_ok(longint lag, logic [63:0] since);
         logic [31:0] draw;
         logic [31:0] skipc;
         draw  = cost[0];
         skipc = cost[1];
         if (lag < 2) return 1'b0;
         if (skip_run >= SKIP_CAP) return 1'b0;
         if (mode != MODE_SMOOTH) return 1'b1;
         if (skipc == 32'd0) skipc = (draw > cost[3]) ? draw - cost[3] : 32'd0;
         return (since + 64'(skipc) + 64'(draw)) <= 64'(floor_us);
      endfunction

      function void take_event(pacer_event_type ev);
         result_type  r;
         logic [31:0] d;
         longint      lag;
         bit          skip;
         logic [31:0] rest;
         logic [63:0] since;
         logic [31:0] cost_now;
         r = '0;
         case (ev.kind)
            REQ_BEGIN: begin
               skip       = 1'b0;
               iter_start = ev.t_us;
               decide_at  = ev.t_us;
               ok_now     = (ev.div == 4'd2) && (mode != MODE_OFF) && ev.ctx;
               if (!ok_now) begin
                  clock_run = 1'b0;
               end else begin
                  if (!clock_run || ev.div != prev_div) begin
                     anchor_vb = ev.retrace;
                     ticks     = '0;
                     clock_run = 1'b1;
                  end
                  d   = ev.retrace - (anchor_vb + (ticks << 1));
                  lag = longint'($signed(d));
                  if (lag > REANCHOR_VB) begin
                     anchor_vb = ev.retrace - (ticks << 1);
                     lag       = 0;
                  end else if (lag > 2 * (SKIP_CAP + 1)) begin
                     anchor_vb = anchor_vb + 32'(lag - 2 * SKIP_CAP);
                     lag       = 2 * SKIP_CAP;
                  end
                  if (variant == VAR_BEGIN) begin
                     skip = skip_ok(lag, {16'd0, elapsed(ev.t_us, last_present)});
                  end
               end
               prev_div = ev.div;
               if (variant >= VAR_AHEAD) begin
                  skip         = drop_pending;
                  drop_pending = 1'b0;
               end
               if (skip) begin
                  if (skip_run < SKIP_RUN_MAX) skip_run = skip_run + 4'd1;
               end else begin
                  skip_run = '0;
               end
               skip_flag = skip;
            end
            REQ_DECIDE: begin
               if (variant >= VAR_AHEAD) begin
                  skip      = 1'b0;
                  decide_at = ev.t_us;
                  if (ok_now && clock_run && mode != MODE_OFF && ev.ctx) begin
                     rest  = cost[2];
                     d     = ev.retrace - (anchor_vb + ((ticks + 32'd1) << 1));
                     lag   = longint'($signed(d)) + longint'(rest / VBLANK_US);
                     since = skip_flag ?
                             {16'd0, elapsed(ev.t_us, last_present)} + {32'd0, rest} : 64'd0;
                     skip  = skip_ok(lag, since);
                  end
                  drop_pending  = skip;
                  r.drop_models = skip;
               end
            end
            REQ_RENDER: begin
               if (!skip_flag) cost[3] = avg8(cost[3], clip32(elapsed(ev.t_us, iter_start)));
            end
            REQ_END: begin
               cost_now = clip32(elapsed(ev.t_us, iter_start));
               if (skip_flag) begin
                  cost[1]     = avg8(cost[1], cost_now);
                  drawn_iters = '0;
               end else begin
                  cost[0]      = avg8(cost[0], cost_now);
                  last_present = ev.t_us;
                  if (drawn_iters < DRAWN_MAX) drawn_iters = drawn_iters + 6'd1;
                  if (drawn_iters > STALE_LIMIT) cost[1] = '0;
               end
               if (variant >= VAR_AHEAD) begin
                  cost[2] = avg8(cost[2], clip32(elapsed(ev.t_us, decide_at)));
               end
               if (clock_run) begin
                  ticks        = ticks + 32'd1;
                  r.due_vblank = anchor_vb + (ticks << 1);
                  r.paced      = 1'b1;
               end
               skip_flag = 1'b0;
            end
            REQ_ITASK: begin
               if (!skip_flag) begin
                  idle_cnt    = '0;
                  r.itask_run = 1'b1;
               end else begin
                  idle_cnt = idle_cnt + 3'd1;
                  if (idle_cnt >= IDLE_LIMIT) begin
                     idle_cnt    = '0;
                     r.itask_run = 1'b1;
                  end
               end
            end
            REQ_RESET: begin
               clock_run    = 1'b0;
               ok_now       = 1'b0;
               skip_run     = '0;
               drop_pending = 1'b0;
               skip_flag    = 1'b0;
            end
            default: ;
         endcase
         r.skipping = skip_flag;
         decisions.push_back(r);
      endfunction

      function int pending();
         return decisions.size();
      endfunction

      task report(string msg);
         $display("ERROR: %s", msg);
         mismatches++;
      endtask

      task match_result(logic [39:0] beat);
         result_type w;
         if (decisions.size() == 0) begin
            report($sformatf("result beat %h with no event pending", beat));
            return;
         end
         w = decisions.pop_front();
         if (beat[0] !== w.skipping) begin
            report($sformatf("skipping: expected %0d got %0d", w.skipping, beat[0]));
         end
         if (beat[1] !== w.drop_models) begin
            report($sformatf("drop_models: expected %0d got %0d", w.drop_models, beat[1]));
         end
         if (beat[2] !== w.paced) begin
            report($sformatf("paced: expected %0d got %0d", w.paced, beat[2]));
         end
         if (beat[34:3] !== w.due_vblank) begin
            report($sformatf("due_vblank: expected %h got %h", w.due_vblank, beat[34:3]));
         end
         if (beat[35] !== w.itask_run) begin
            report($sformatf("itask_run: expected %0d got %0d", w.itask_run, beat[35]));
         end
      endtask

   endclass

endpackage

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// bench for frame_skip_pacer: a short directed run of edge cases, then
// phases of game-loop shaped event streams with noise under several register
// settings, random gaps on both sides and one long result hold-off
// ----------------------------------------------------------------------------
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   import fsp_pkg::*;
   import pacer_check_pkg::*;

   localparam int ITEMS_PER_PHASE = 92;
   localparam int NUM_PHASES      = 9;
   localparam int HOLD_OFF_CYCLES = 160;
   localparam int DRAIN_CYCLES    = 16;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // retrace_count[31:0], time_us[79:32], vsync_divisor[83:80],
   // in_play[84], zero[87:85]
   logic [87:0] req_tdata  = '0;
   // req_type[2:0]
   logic [2:0]  req_tuser  = '0;

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // skipping[0], drop_models[1], paced[2], due_vblank[34:3], itask_run[35],
   // zero[39:36]
   logic [39:0] rsp_tdata;

   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = '0;
   logic [19:0] csr_data   = '0;

   pacer_scoreboard_type sb;

   bit          idle_on      = 1'b1;
   bit          hold_off_req = 1'b0;
   int          hold_left    = 0;
   int          stall_left   = 0;
   int          items_sent   = 0;

   // running position of the simulated game loop
   logic [31:0] loop_vb;
   logic [47:0] loop_us;

   // register settings per random phase, extremes included
   logic [1:0]  mode_plan [NUM_PHASES] = '{MODE_SMOOTH, MODE_FAST, MODE_SMOOTH, MODE_OFF,
                                           MODE_ALT, MODE_SMOOTH, MODE_SMOOTH, MODE_FAST,
                                           MODE_SMOOTH};
   logic [1:0]  variant_plan [NUM_PHASES] = '{VAR_BEGIN, VAR_BEGIN, VAR_AHEAD, VAR_BEGIN,
                                              VAR_AHEAD, VAR_ALT, VAR_NEVER, VAR_AHEAD,
                                              VAR_BEGIN};
   logic [19:0] floor_plan [NUM_PHASES] = '{20'd0, 20'(FLOOR_RESET), 20'hFFFFF,
                                            20'(FLOOR_RESET), 20'd50000, 20'(FLOOR_RESET),
                                            20'd100000, 20'd1000000, 20'd40000};

   always #4 clock = ~clock;

   frame_skip_pacer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85) return int'($urandom_range(1, 3));
      return int'($urandom_range(10, 40));
   endfunction

   function automatic pacer_event_type mk_event(logic [2:0] kind, logic [31:0] vb,
                                                logic [47:0] t, logic [3:0] div, logic ctx);
      pacer_event_type ev;
      ev.kind    = kind;
      ev.retrace = vb;
      ev.t_us    = t;
      ev.div     = div;
      ev.ctx     = ctx;
      return ev;
   endfunction

   // result side: random stalls, plus the long hold-off counted here
   always @(negedge clock) begin
      if (hold_off_req) begin
         hold_left    = HOLD_OFF_CYCLES;
         hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 20) begin
         stall_left = pick_gap() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // every result beat is checked against the oldest pending decision
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.match_result(rsp_tdata);
   end

   // one event beat; valid stays high into the next call unless a gap is drawn
   task automatic send_event(pacer_event_type ev);
      int gap;
      gap = (idle_on && $urandom_range(0, 99) < 20) ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= ev.kind;
      req_tdata  <= {3'b000, ev.ctx, ev.div, ev.t_us, ev.retrace};
      do @(posedge clock); while (!req_tready);
      sb.take_event(ev);
      items_sent++;
   endtask

   task automatic write_reg(logic [1:0] idx, logic [19:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop offering and wait until every pending decision has come back
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one game-loop iteration with random content, now and then broken or noisy
   task automatic run_iteration();
      int              r;
      int              step;
      int              cost_r;
      int              cost_e;
      logic [47:0]     t0;
      logic [3:0]      div;
      logic            ctx;
      pacer_event_type junk;
      r = $urandom_range(0, 99);
      if (r < 5) begin
         junk.kind    = 3'($urandom_range(0, 7));
         junk.retrace = $urandom;
         junk.t_us    = {16'($urandom), 32'($urandom)};
         junk.div     = 4'($urandom);
         junk.ctx     = 1'($urandom);
         send_event(junk);
      end else if (r < 7) begin
         send_event(mk_event(REQ_RESET, loop_vb, loop_us, 4'd2, 1'b1));
      end else if (r < 9) begin
         send_event(mk_event($urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B,
                             loop_vb, loop_us, 4'd2, 1'b1));
      end
      // lag behind the tick clock: mostly on time, some late, rarely far off
      r = $urandom_range(0, 99);
      if (r < 55) step = 2;
      else if (r < 75) step = $urandom_range(3, 4);
      else if (r < 88) step = $urandom_range(0, 1);
      else if (r < 96) step = $urandom_range(5, 12);
      else step = $urandom_range(31, 45);
      loop_vb = loop_vb + 32'(step);
      loop_us = loop_us + 48'(step * VBLANK_US) + 48'($urandom_range(0, 3000));
      // rare large time jump so that costs saturate
      if ($urandom_range(0, 99) == 0) loop_us = loop_us + {16'($urandom), 32'($urandom)};
      div = ($urandom_range(0, 9) != 0) ? 4'd2 : 4'($urandom_range(0, 15));
      ctx = ($urandom_range(0, 14) != 0);
      t0  = loop_us;
      send_event(mk_event(REQ_BEGIN, loop_vb, t0, div, ctx));
      if ($urandom_range(0, 3) != 0) begin
         send_event(mk_event(REQ_DECIDE, loop_vb + 32'($urandom_range(0, 3)),
                             t0 + 48'($urandom_range(500, 8000)), div, ctx));
      end
      if ($urandom_range(0, 1) != 0) send_event(mk_event(REQ_ITASK, loop_vb, t0, div, ctx));
      cost_r = $urandom_range(2000, 40000);
      if ($urandom_range(0, 99) < 85) begin
         send_event(mk_event(REQ_RENDER, loop_vb + 32'(cost_r / VBLANK_US),
                             t0 + 48'(cost_r), div, ctx));
      end
      if ($urandom_range(0, 9) < 3) send_event(mk_event(REQ_ITASK, loop_vb, t0, div, ctx));
      cost_e  = cost_r + $urandom_range(500, 30000);
      loop_us = t0 + 48'(cost_e);
      loop_vb = loop_vb + 32'(cost_e / VBLANK_US);
      // an end is sometimes left out
      if ($urandom_range(0, 24) != 0) begin
         send_event(mk_event(REQ_END, loop_vb, loop_us, div, ctx));
      end
   endtask

   initial begin
      int phase_end;
      sb = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      loop_vb = $urandom;
      loop_us = {16'($urandom), 32'($urandom)};

      // directed: default registers, clock start across the vblank wrap
      send_event(mk_event(REQ_BEGIN, 32'hFFFF_FFFE, 48'd0, 4'd2, 1'b1));
      // decide does nothing outside the drop-ahead variant
      send_event(mk_event(REQ_DECIDE, 32'hFFFF_FFFE, 48'd1000, 4'd2, 1'b1));
      send_event(mk_event(REQ_RENDER, 32'hFFFF_FFFE, 48'd8000, 4'd2, 1'b1));
      send_event(mk_event(REQ_ITASK, 32'hFFFF_FFFE, 48'd9000, 4'd2, 1'b1));
      send_event(mk_event(REQ_END, 32'hFFFF_FFFF, 48'd20000, 4'd2, 1'b1));
      // late by three vblanks: skipped iteration
      send_event(mk_event(REQ_BEGIN, 32'h0000_0003, 48'd30000, 4'd2, 1'b1));
      // itask runs again on the fourth query while skipping
      repeat (4) send_event(mk_event(REQ_ITASK, 32'h0000_0003, 48'd31000, 4'd2, 1'b1));
      send_event(mk_event(REQ_RENDER, 32'h0000_0003, 48'd33000, 4'd2, 1'b1));
      send_event(mk_event(REQ_END, 32'h0000_0003, 48'd35000, 4'd2, 1'b1));
      // lag past the cap: anchor moves forward, skip cap holds the run
      send_event(mk_event(REQ_BEGIN, 32'h0000_0010, 48'd40000, 4'd2, 1'b1));
      send_event(mk_event(REQ_END, 32'h0000_0010, 48'd41000, 4'd2, 1'b1));
      // lag past the re-anchor limit
      send_event(mk_event(REQ_BEGIN, 32'h0000_0050, 48'd90000, 4'd2, 1'b1));
      send_event(mk_event(REQ_END, 32'h0000_0051, 48'd95000, 4'd2, 1'b1));
      send_event(mk_event(REQ_RESET, 32'h0000_0051, 48'd96000, 4'd2, 1'b1));
      // unused codes are ignored
      send_event(mk_event(REQ_SPARE_A, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'd15, 1'b1));
      send_event(mk_event(REQ_SPARE_B, 32'h0000_0000, 48'd0, 4'd0, 1'b0));
      // field extremes, wrong divisor and context off stop the clock
      send_event(mk_event(REQ_BEGIN, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 4'd15, 1'b0));
      send_event(mk_event(REQ_END, 32'h0000_0000, 48'd5, 4'd15, 1'b0));
      send_event(mk_event(REQ_BEGIN, 32'hFFFF_FFFF, 48'd100, 4'd0, 1'b1));
      send_event(mk_event(REQ_BEGIN, 32'h8000_0000, 48'h8000_0000_0000, 4'd2, 1'b0));
      send_event(mk_event(REQ_ITASK, 32'h8000_0000, 48'h8000_0000_0001, 4'd2, 1'b0));
      settle();

      for (int p = 0; p < NUM_PHASES; p++) begin
         // registers change only with nothing in flight
         write_reg(CSR_MODE, {18'($urandom), mode_plan[p]});
         write_reg(CSR_VARIANT, {18'($urandom), variant_plan[p]});
         write_reg(CSR_FLOOR, (p == NUM_PHASES - 1) ? 20'($urandom_range(0, 1000000))
                                                    : floor_plan[p]);
         if (p == 3) write_reg(CSR_UNUSED, 20'($urandom));
         // phases 0 and 5 run with no idling at all
         idle_on = (p != 0 && p != 5);
         // long result hold-off while events keep coming, block fills up
         if (p == 1) hold_off_req = 1'b1;
         phase_end = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_end) run_iteration();
         settle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) sb.report($sformatf("%0d decisions never came back", sb.pending()));
      if (sb.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // run limit, far above the slowest legal run
   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: frame_skip_pacer.f
design/fsp_pkg.sv
design/fsp_vblank_div.sv
design/fsp_core.sv
design/frame_skip_pacer.sv
tb/pacer_check_pkg.sv
tb/tb.sv
